// ===== rtl/core/bpws_pkg.sv =====
// ----------------------------------------------------------------------------
// bpws_pkg
// Shared widths, codes and word types of the block pool write scatter engine.
// ----------------------------------------------------------------------------
package bpws_pkg;

	localparam int NUM_BLOCKS_DEF = 32;

	localparam int BSIZE_W   = 21;
	localparam int BIU_W     = 6;
	localparam int EXT_W     = 31;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int MSG_W     = 24;
	localparam int OFF_W     = 48;
	localparam int BIDX_W    = 5;

	localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = BSIZE_W'(65536);
	localparam logic [BIU_W-1:0]   BIU_RST        = BIU_W'(32);
	localparam logic [EXT_W-1:0]   EXTENT_RST     = EXT_W'(32'd16 << 20);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_SIZE   = 2'd2;

	// input operations
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_WDONE  = 2'd1;
	localparam logic [1:0] OP_XDONE  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_VERDICT = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_EXTEND  = 2'd2;
	localparam logic [1:0] KIND_STATUS  = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [MSG_W-1:0] msg_bytes;
		logic [4:0]       done_block;
		logic             done_failed;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              retry;
		logic [BIDX_W-1:0] block_index;
		logic [OFF_W-1:0]  file_offset;
		logic              fault;
		logic              last;
	} out_word_t;

	// block_size is the effective size: zero reads as one byte
	typedef struct packed {
		logic [BSIZE_W-1:0] block_size;
		logic [BIU_W-1:0]   blocks_in_use;
		logic [EXT_W-1:0]   extent_size;
		logic               rebuild;
	} cfg_t;

endpackage

// ===== rtl/core/bpws_ram.sv =====
// ----------------------------------------------------------------------------
// bpws_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bpws_cfg.sv =====
// ----------------------------------------------------------------------------
// bpws_cfg
// Configuration registers; flags a pool rebuild when blocks_in_use is written.
// ----------------------------------------------------------------------------
module bpws_cfg
	import bpws_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [CFG_IDX_W-1:0] index,
	input  logic [CFG_W-1:0]     data,
	output cfg_t                 cfg
);

	logic [BSIZE_W-1:0] block_size_q;
	logic [BIU_W-1:0]   blocks_in_use_q;
	logic [EXT_W-1:0]   extent_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q    <= BLOCK_SIZE_RST;
			blocks_in_use_q <= BIU_RST;
			extent_size_q   <= EXTENT_RST;
		end else if (we) begin
			case (index)
				REG_BLOCK_SIZE:    block_size_q    <= data[BSIZE_W-1:0];
				REG_BLOCKS_IN_USE: blocks_in_use_q <= data[BIU_W-1:0];
				REG_EXTENT_SIZE:   extent_size_q   <= data[EXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.block_size    = (block_size_q == '0) ? BSIZE_W'(1) : block_size_q;
		cfg.blocks_in_use = blocks_in_use_q;
		cfg.extent_size   = extent_size_q;
		cfg.rebuild       = we && (index == REG_BLOCKS_IN_USE);
	end

endmodule

// ===== rtl/core/bpws_oreg.sv =====
// ----------------------------------------------------------------------------
// bpws_oreg
// Output register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module bpws_oreg
	import bpws_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_word_t word,
	output logic      free,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic      valid_q;
	out_word_t word_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload: load on push only, hold while stalled
	always_ff @(posedge clk) begin
		if (push) begin
			word_q <= word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// ===== rtl/core/bpws_engine.sv =====
// ----------------------------------------------------------------------------
// bpws_engine
// Pool sequencer: read-modify-write of the block table RAM (link, busy, fill),
// free-list pops and pushes, file offset and extension bookkeeping.
// ----------------------------------------------------------------------------
module bpws_engine
	import bpws_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      emit,
	output out_word_t emit_word,
	input  logic      out_free
);

	localparam int IW       = $clog2(NUM_BLOCKS);
	localparam int POOL_MAX = (NUM_BLOCKS < 63) ? NUM_BLOCKS : 63;
	localparam int CW       = $clog2(POOL_MAX + 1);
	localparam int PW       = CW + BSIZE_W;

	typedef struct packed {
		logic               busy;
		logic [BSIZE_W-1:0] fill;
		logic [IW-1:0]      link;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_FREE,
		S_A_FIT,
		S_A_ROOM,
		S_EXT,
		S_ISSUE,
		S_FILL,
		S_W_DONE,
		S_STATUS,
		S_VERDICT
	} state_t;

	state_t             state_q;
	logic [IW-1:0]      clr_q;
	logic [IW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [OFF_W-1:0]   wpos_q;
	logic [OFF_W-1:0]   aend_q;
	logic               pend_q;
	logic [IW-1:0]      cur_q;
	logic [MSG_W-1:0]   sz_q;
	logic [MSG_W-1:0]   rem_q;
	logic [BSIZE_W-1:0] cur_free_q;
	logic [PW-1:0]      prod_q;
	logic [OFF_W-1:0]   avail_q;
	logic               past_q;
	logic               failed_q;
	logic               fault_q;
	logic               retry_q;

	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	ent_t             ram_wdata;
	logic             ram_re;
	logic [IW-1:0]    ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	ent_t             ent_rd;

	logic          accept;
	logic          blk_ok;
	logic [CW-1:0] pool_c;
	logic [CW-1:0] cnt_dec;
	logic [IW-1:0] clr_link;
	logic          loop_go;
	logic          fill_go;

	bpws_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ent_rd   = ent_t'(ram_rdata);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign pool_c   = (int'(cfg.blocks_in_use) < NUM_BLOCKS) ? CW'(cfg.blocks_in_use)
	                                                          : CW'(NUM_BLOCKS);
	assign blk_ok   = int'(in_word.done_block) < int'(pool_c);
	assign cnt_dec  = count_q - CW'(1);
	assign clr_link = (clr_q == IW'(NUM_BLOCKS - 1)) ? '0 : clr_q + IW'(1);
	assign loop_go  = (rem_q >= MSG_W'(cfg.block_size)) && (cnt_dec != '0);
	assign fill_go  = (rem_q != '0) && (cnt_dec != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = ent_rd;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		emit      = 1'b0;
		emit_word = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we         = 1'b1;
				ram_waddr      = clr_q;
				ram_wdata.busy = 1'b0;
				ram_wdata.fill = '0;
				ram_wdata.link = clr_link;
			end
			S_IDLE: begin
				if (accept && in_word.op == OP_APPEND && count_q != '0) begin
					ram_re = 1'b1;
				end else if (accept && in_word.op == OP_WDONE && blk_ok) begin
					ram_re    = 1'b1;
					ram_raddr = IW'(in_word.done_block);
				end
			end
			S_A_FIT: begin
				if (sz_q < MSG_W'(cur_free_q)) begin
					ram_we         = 1'b1;
					ram_waddr      = head_q;
					ram_wdata.fill = ent_rd.fill + BSIZE_W'(sz_q);
				end
			end
			S_EXT: begin
				if (out_free) begin
					emit                  = 1'b1;
					emit_word.kind        = KIND_EXTEND;
					emit_word.file_offset = aend_q;
				end
			end
			S_ISSUE: begin
				if (out_free) begin
					emit                  = 1'b1;
					emit_word.kind        = KIND_WRITE;
					emit_word.block_index = BIDX_W'(cur_q);
					emit_word.file_offset = wpos_q;
					ram_we                = 1'b1;
					ram_wdata.busy        = 1'b1;
					// fetch the new head while the popped block is marked busy
					if (loop_go || fill_go) begin
						ram_re    = 1'b1;
						ram_raddr = ent_rd.link;
					end
				end
			end
			S_FILL: begin
				ram_we         = 1'b1;
				ram_wdata.fill = BSIZE_W'(rem_q);
			end
			S_W_DONE: begin
				if (out_free) begin
					emit            = 1'b1;
					emit_word.kind  = KIND_STATUS;
					emit_word.fault = ent_rd.busy ? failed_q : 1'b1;
					emit_word.last  = 1'b1;
					if (ent_rd.busy) begin
						ram_we         = 1'b1;
						ram_wdata.busy = 1'b0;
						ram_wdata.fill = '0;
						ram_wdata.link = (count_q != '0) ? head_q : '0;
					end
				end
			end
			S_STATUS: begin
				if (out_free) begin
					emit            = 1'b1;
					emit_word.kind  = KIND_STATUS;
					emit_word.fault = fault_q;
					emit_word.last  = 1'b1;
				end
			end
			S_VERDICT: begin
				if (out_free) begin
					emit            = 1'b1;
					emit_word.kind  = KIND_VERDICT;
					emit_word.retry = retry_q;
					emit_word.last  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			count_q    <= '0;
			wpos_q     <= '0;
			aend_q     <= '0;
			pend_q     <= 1'b0;
			cur_q      <= '0;
			sz_q       <= '0;
			rem_q      <= '0;
			cur_free_q <= '0;
			prod_q     <= '0;
			avail_q    <= '0;
			past_q     <= 1'b0;
			failed_q   <= 1'b0;
			fault_q    <= 1'b0;
			retry_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_link;
					if (clr_q == IW'(NUM_BLOCKS - 1)) begin
						head_q  <= '0;
						count_q <= pool_c;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						sz_q     <= in_word.msg_bytes;
						failed_q <= in_word.done_failed;
						case (in_word.op)
							OP_APPEND: begin
								if (count_q == '0) begin
									retry_q <= 1'b1;
									state_q <= S_VERDICT;
								end else begin
									prod_q  <= PW'(cnt_dec) * PW'(cfg.block_size);
									avail_q <= aend_q - wpos_q;
									past_q  <= wpos_q > aend_q;
									state_q <= S_A_FREE;
								end
							end
							OP_WDONE: begin
								if (blk_ok) begin
									cur_q   <= IW'(in_word.done_block);
									state_q <= S_W_DONE;
								end else begin
									fault_q <= 1'b1;
									state_q <= S_STATUS;
								end
							end
							OP_XDONE: begin
								if (pend_q) begin
									if (!in_word.done_failed) begin
										aend_q <= aend_q + OFF_W'(cfg.extent_size);
									end
									pend_q  <= 1'b0;
									fault_q <= in_word.done_failed;
								end else begin
									fault_q <= 1'b1;
								end
								state_q <= S_STATUS;
							end
							default: begin
							end
						endcase
					end
				end
				S_A_FREE: begin
					cur_free_q <= (ent_rd.fill < cfg.block_size)
					              ? cfg.block_size - ent_rd.fill : '0;
					state_q    <= S_A_FIT;
				end
				S_A_FIT: begin
					if (sz_q < MSG_W'(cur_free_q)) begin
						retry_q <= 1'b0;
						state_q <= S_VERDICT;
					end else begin
						rem_q   <= sz_q - MSG_W'(cur_free_q);
						state_q <= S_A_ROOM;
					end
				end
				S_A_ROOM: begin
					if (OFF_W'(rem_q) > OFF_W'(prod_q)) begin
						retry_q <= 1'b1;
						state_q <= S_VERDICT;
					end else if (past_q || OFF_W'(rem_q) > avail_q) begin
						// short on file space: ask for one extension at most
						retry_q <= 1'b1;
						state_q <= pend_q ? S_VERDICT : S_EXT;
					end else begin
						cur_q   <= head_q;
						state_q <= S_ISSUE;
					end
				end
				S_EXT: begin
					if (out_free) begin
						pend_q  <= 1'b1;
						state_q <= S_VERDICT;
					end
				end
				S_ISSUE: begin
					if (out_free) begin
						wpos_q  <= wpos_q + OFF_W'(cfg.block_size);
						count_q <= cnt_dec;
						head_q  <= ent_rd.link;
						if (loop_go) begin
							rem_q <= rem_q - MSG_W'(cfg.block_size);
							cur_q <= ent_rd.link;
						end else if (fill_go) begin
							cur_q   <= ent_rd.link;
							state_q <= S_FILL;
						end else begin
							retry_q <= 1'b0;
							state_q <= S_VERDICT;
						end
					end
				end
				S_FILL: begin
					retry_q <= 1'b0;
					state_q <= S_VERDICT;
				end
				S_W_DONE: begin
					if (out_free) begin
						if (ent_rd.busy) begin
							head_q  <= cur_q;
							count_q <= count_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_STATUS, S_VERDICT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// rebuild the pool: sweep the table from entry zero
			if (cfg.rebuild) begin
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end
		end
	end

	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("table read and write hit the same entry");

	a_issue_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ISSUE |-> count_q != '0)
		else $error("block issued from an empty free list");

	a_fill_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> rem_q != '0 && rem_q < MSG_W'(cfg.block_size))
		else $error("tail fill out of range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |-> int'(count_q) <= int'(pool_c))
		else $error("free count above pool size");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result pushed into a full output register");

endmodule

// ===== rtl/core/block_pool_write_scatter.sv =====
// An append reads the head block entry, works out its free room and, if the message fits,
// adds it to the head fill and gives its verdict; one that spills checks pool and file room,
// then issues one write per block, stores any tail in the new head and gives its verdict.
// One item is in work at a time; the read of the next head overlaps the busy write of
// each popped block. Reset, and any write of blocks_in_use, starts a sweep of the table;
// in_stall stays high until it ends. Register values reset to their documented defaults.
// ----------------------------------------------------------------------------
// block_pool_write_scatter
// Descriptor engine for a LIFO pool of fixed-size write blocks with file
// offset tracking and extension requests.
// ----------------------------------------------------------------------------
module block_pool_write_scatter
	import bpws_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t      cfg;
	logic      emit;
	out_word_t emit_word;
	logic      out_free;

	bpws_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	bpws_engine #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.emit      (emit),
		.emit_word (emit_word),
		.out_free  (out_free)
	);

	bpws_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.word      (emit_word),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== verif/bpws_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpws_monitor
// Watches the input, output and register ports of the block pool write
// scatter engine. It keeps its own copy of the free list, the block table and
// the file offsets, works out the words each accepted input word must cause,
// and compares every accepted output word with the oldest one still due.
// ----------------------------------------------------------------------------
module bpws_monitor
	import bpws_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_word_t             in_word,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   words_due
);

	logic [BIDX_W-1:0]  link_tbl [NUM_BLOCKS_DEF];
	logic               busy_tbl [NUM_BLOCKS_DEF];
	logic [BSIZE_W-1:0] fill_tbl [NUM_BLOCKS_DEF];
	logic [BIDX_W-1:0]  head;
	int unsigned        nfree;
	logic [OFF_W-1:0]   wpos;
	logic [OFF_W-1:0]   aend;
	logic               ext_pend;

	logic [BSIZE_W-1:0] bsize_reg;
	logic [BIU_W-1:0]   biu_reg;
	logic [EXT_W-1:0]   extent_reg;

	out_word_t due_words [$];
	out_word_t want;

	function automatic int unsigned pool_size();
		return (biu_reg < NUM_BLOCKS_DEF) ? biu_reg : NUM_BLOCKS_DEF;
	endfunction

	task automatic rebuild_pool();
		for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
			link_tbl[i] = BIDX_W'((i + 1) % NUM_BLOCKS_DEF);
			busy_tbl[i] = 1'b0;
			fill_tbl[i] = '0;
		end
		head = '0;
		nfree = pool_size();
	endtask

	task automatic expect_word(input logic [1:0] kind, input logic retry,
			input logic [BIDX_W-1:0] idx, input logic [OFF_W-1:0] off, input logic fault);
		out_word_t w;
		w.kind = kind;
		w.retry = retry;
		w.block_index = idx;
		w.file_offset = off;
		w.fault = fault;
		w.last = 1'b0;
		due_words.push_back(w);
	endtask

	task automatic issue_head(input logic [63:0] bs);
		logic [BIDX_W-1:0] idx;
		idx = head;
		head = link_tbl[idx];
		busy_tbl[idx] = 1'b1;
		nfree--;
		expect_word(KIND_WRITE, 1'b0, idx, wpos, 1'b0);
		wpos = wpos + OFF_W'(bs);
	endtask

	task automatic predict_append(input logic [63:0] sz);
		logic [63:0] bs;
		logic [63:0] fill;
		logic [63:0] room;
		logic [63:0] spill;
		logic [63:0] rem;
		bs = (bsize_reg == '0) ? 64'd1 : 64'(bsize_reg);
		if (nfree == 0) begin
			expect_word(KIND_VERDICT, 1'b1, '0, '0, 1'b0);
		end else begin
			// a head block filled past a shrunken block size has no room left
			fill = 64'(fill_tbl[head]);
			room = (fill < bs) ? bs - fill : 64'd0;
			spill = sz - room;
			if (sz < room) begin
				fill_tbl[head] = BSIZE_W'(fill + sz);
				expect_word(KIND_VERDICT, 1'b0, '0, '0, 1'b0);
			end else if (spill > 64'(nfree - 1) * bs) begin
				expect_word(KIND_VERDICT, 1'b1, '0, '0, 1'b0);
			end else if (wpos > aend || spill > 64'(aend - wpos)) begin
				if (!ext_pend) begin
					expect_word(KIND_EXTEND, 1'b0, '0, aend, 1'b0);
					ext_pend = 1'b1;
				end
				expect_word(KIND_VERDICT, 1'b1, '0, '0, 1'b0);
			end else begin
				issue_head(bs);
				rem = spill;
				while (rem >= bs && nfree > 0) begin
					issue_head(bs);
					rem = rem - bs;
				end
				// park the tail bytes in the new head block
				if (rem > 0 && nfree > 0)
					fill_tbl[head] = BSIZE_W'(rem);
				expect_word(KIND_VERDICT, 1'b0, '0, '0, 1'b0);
			end
		end
	endtask

	task automatic predict_item(input in_word_t w);
		int unsigned n_before;
		logic        flt;
		out_word_t   tail;
		n_before = due_words.size();
		flt = 1'b1;
		case (w.op)
			OP_APPEND: predict_append(64'(w.msg_bytes));
			OP_WDONE: begin
				if (w.done_block < pool_size() && busy_tbl[w.done_block]) begin
					fill_tbl[w.done_block] = '0;
					busy_tbl[w.done_block] = 1'b0;
					link_tbl[w.done_block] = (nfree != 0) ? head : '0;
					head = w.done_block;
					nfree++;
					flt = w.done_failed;
				end
				expect_word(KIND_STATUS, 1'b0, '0, '0, flt);
			end
			OP_XDONE: begin
				if (ext_pend) begin
					if (!w.done_failed)
						aend = aend + OFF_W'(extent_reg);
					ext_pend = 1'b0;
					flt = w.done_failed;
				end
				expect_word(KIND_STATUS, 1'b0, '0, '0, flt);
			end
			default: ;
		endcase
		if (due_words.size() > n_before) begin
			tail = due_words[due_words.size() - 1];
			tail.last = 1'b1;
			due_words[due_words.size() - 1] = tail;
		end
	endtask

	task automatic check_field(input string name, input logic [OFF_W-1:0] exp_val,
			input logic [OFF_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_reg = BLOCK_SIZE_RST;
			biu_reg = BIU_RST;
			extent_reg = EXTENT_RST;
			rebuild_pool();
			wpos = '0;
			aend = '0;
			ext_pend = 1'b0;
			due_words.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$error("unexpected word: kind %0d block %0d offset %0d", out_word.kind,
						out_word.block_index, out_word.file_offset);
					fail_count++;
				end else begin
					want = due_words.pop_front();
					check_field("kind", want.kind, out_word.kind);
					check_field("retry", want.retry, out_word.retry);
					check_field("block_index", want.block_index, out_word.block_index);
					check_field("file_offset", want.file_offset, out_word.file_offset);
					check_field("fault", want.fault, out_word.fault);
					check_field("last", want.last, out_word.last);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_SIZE:    bsize_reg = cfg_data[BSIZE_W-1:0];
					REG_BLOCKS_IN_USE: begin
						biu_reg = cfg_data[BIU_W-1:0];
						rebuild_pool();
					end
					REG_EXTENT_SIZE:   extent_reg = cfg_data[EXT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item(in_word);
		end
		words_due = due_words.size();
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the block pool write scatter engine: a directed pass over the
// verdicts, faults and register corner cases, then random traffic under
// several register settings, with completions fed back for the blocks and
// extensions the engine asks for. Checking is done by bpws_monitor.
// ----------------------------------------------------------------------------
module testbench;
	import bpws_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_word_t             in_word;
	logic                 out_valid;
	logic                 out_stall;
	out_word_t            out_word;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   words_due;
	int                   cycle_count;

	int unsigned       blk_bytes;
	logic [BIDX_W-1:0] issued_q [$];
	logic              ext_open;
	logic              idle_on;
	logic              hold_req;

	block_pool_write_scatter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bpws_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("block_pool_write_scatter test failed");
		$finish;
	end

	// note issued blocks and extension requests so completions can follow
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (out_word.kind == KIND_WRITE)
				issued_q.push_back(out_word.block_index);
			else if (out_word.kind == KIND_EXTEND)
				ext_open = 1'b1;
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [MSG_W-1:0] msg,
			input logic [4:0] blk, input logic failed);
		in_word_t w;
		// unused fields carry random bits
		w = in_word_t'($urandom);
		w.op = op;
		if (op == OP_APPEND)
			w.msg_bytes = msg;
		if (op == OP_WDONE)
			w.done_block = blk;
		if (op == OP_WDONE || op == OP_XDONE)
			w.done_failed = failed;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_BLOCK_SIZE)
			blk_bytes = val & 32'h1F_FFFF;
		if (idx == REG_BLOCKS_IN_USE)
			issued_q.delete();
	endtask

	task automatic set_config(input int unsigned bsize, input int unsigned biu,
			input int unsigned extent);
		write_reg(REG_BLOCK_SIZE, bsize);
		write_reg(REG_BLOCKS_IN_USE, biu);
		write_reg(REG_EXTENT_SIZE, extent);
	endtask

	function automatic logic [MSG_W-1:0] pick_msg();
		longint unsigned b;
		longint unsigned v;
		b = (blk_bytes == 0) ? 1 : blk_bytes;
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom_range(0, b - 1);
			3, 4, 5: v = b * $urandom_range(0, 2) + $urandom_range(0, b);
			6:       v = b * $urandom_range(3, 33) + $urandom_range(0, b - 1);
			7:       v = b;
			8:       v = $urandom_range(0, 15);
			default: v = $urandom;
		endcase
		return MSG_W'(v);
	endfunction

	task automatic run_traffic(input int n_items);
		int         pick;
		int         slot;
		logic [4:0] blk;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (ext_open && pick < 25) begin
				ext_open = 1'b0;
				send_item(OP_XDONE, '0, '0, $urandom_range(0, 7) == 0);
			end else if (issued_q.size() > 0 && pick < 55) begin
				slot = $urandom_range(0, issued_q.size() - 1);
				blk = issued_q[slot];
				issued_q.delete(slot);
				send_item(OP_WDONE, '0, blk, $urandom_range(0, 9) == 0);
			end else if (pick >= 94) begin
				// stray words: unknown op and completions nobody asked for
				send_item(2'($urandom_range(1, 3)), '0, 5'($urandom), 1'($urandom));
			end else begin
				send_item(OP_APPEND, pick_msg(), '0, 1'b0);
			end
		end
	endtask

	initial begin
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		ext_open = 1'b0;
		blk_bytes = BLOCK_SIZE_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: 64 KiB blocks, 32 blocks, no file space yet
		send_item(OP_APPEND, 24'd0, '0, 1'b0);
		send_item(OP_APPEND, 24'd100, '0, 1'b0);
		send_item(2'd3, 24'hABCDEF, 5'd17, 1'b1);
		send_item(OP_APPEND, 24'hFFFFFF, '0, 1'b0);
		send_item(OP_APPEND, 24'd70000, '0, 1'b0);
		send_item(OP_APPEND, 24'd70000, '0, 1'b0);
		send_item(OP_XDONE, '0, '0, 1'b1);
		send_item(OP_XDONE, '0, '0, 1'b0);
		send_item(OP_APPEND, 24'd70000, '0, 1'b0);
		send_item(OP_XDONE, '0, '0, 1'b0);
		send_item(OP_APPEND, 24'd70000, '0, 1'b0);
		send_item(OP_WDONE, '0, 5'd0, 1'b0);
		send_item(OP_WDONE, '0, 5'd0, 1'b0);
		send_item(OP_WDONE, '0, 5'd31, 1'b1);
		send_item(OP_APPEND, 24'd65536, '0, 1'b0);
		send_item(OP_WDONE, '0, 5'd0, 1'b1);
		send_item(OP_APPEND, 24'd0, '0, 1'b0);
		drain();
		issued_q.delete();
		ext_open = 1'b0;

		// completion past the end of a four-block pool
		write_reg(REG_BLOCKS_IN_USE, 4);
		send_item(OP_WDONE, '0, 5'd4, 1'b0);
		drain();
		// zero block size acts as one byte
		write_reg(REG_BLOCK_SIZE, 0);
		send_item(OP_APPEND, 24'd3, '0, 1'b0);
		drain();
		write_reg(REG_BLOCK_SIZE, 4096);
		send_item(OP_APPEND, 24'd3000, '0, 1'b0);
		drain();
		// shrink the block below the head fill
		write_reg(REG_BLOCK_SIZE, 1000);
		send_item(OP_APPEND, 24'd0, '0, 1'b0);
		drain();
		write_reg(REG_BLOCKS_IN_USE, 63);
		send_item(OP_APPEND, 24'd100, '0, 1'b0);
		drain();

		set_config(512, 32, 1073741824);
		hold_req = 1'b1;
		run_traffic(60);
		drain();
		set_config(1048576, 1, 1);
		run_traffic(30);
		drain();
		set_config(0, 63, 16777216);
		run_traffic(40);
		drain();
		set_config(4096, 8, 1000);
		run_traffic(50);
		drain();
		idle_on = 1'b0;
		set_config(2048, 32, 1048576);
		run_traffic(60);
		drain();

		if (fail_count == 0 && words_due == 0) begin
			$display("block_pool_write_scatter test passed");
		end else begin
			$display("block_pool_write_scatter test failed");
		end
		$finish;
	end

endmodule
